/* rtl/bitmap_plane_scroller_unit_assert.svh */
// Assertion macros used by the bitmap plane scroller RTL
`ifndef BITMAP_PLANE_SCROLLER_UNIT_ASSERT_SVH
`define BITMAP_PLANE_SCROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bps_pkg.sv */
// Package of the bitmap plane scroller: widths, codes and shared types
package bps_pkg;

   localparam int PLANE_WIDTH_DEF = 8;
   localparam int PLANE_MAX       = 8;
   localparam int PLANE_BITS      = 64;
   localparam int OFF_W           = $clog2(PLANE_MAX);
   localparam int STEP_W          = 7;
   localparam int GAP_W           = 6;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 6;

   localparam logic [GAP_W-1:0] GAP_MAX = 6'd56;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DN    = 2'd1;
   localparam logic [1:0] DIR_RT    = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LINES = 1'd1;

   typedef struct packed {
      logic [1:0]       dir;
      logic             blank;
      logic [OFF_W-1:0] offset;
   } step_ctl_type;

endpackage

/* rtl/bps_if.sv */
// Channel interfaces of the bitmap plane scroller
interface bps_req_if import bps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PLANE_BITS-1:0] glyph_plane;
   logic                  flush_end;

   modport source (output valid, output glyph_plane, output flush_end, input ready);
   modport sink   (input valid, input glyph_plane, input flush_end, output ready);
endinterface

interface bps_rsp_if import bps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PLANE_BITS-1:0] frame_plane;
   logic                  last_of_run;

   modport source (output valid, output frame_plane, output last_of_run, input ready);
   modport sink   (input valid, input frame_plane, input last_of_run, output ready);
endinterface

/* rtl/bps_shift.sv */
// One scroll step: shift the plane by one line and fill the entering line
module bps_shift import bps_pkg::*; #(
   parameter int PLANE_WIDTH = PLANE_WIDTH_DEF
) (
   input  logic [PLANE_BITS-1:0] cur_plane,
   input  logic [PLANE_BITS-1:0] src_plane,
   input  step_ctl_type          ctl,
   output logic [PLANE_BITS-1:0] next_plane
);

   localparam int IW = $clog2(PLANE_WIDTH);

   logic [IW-1:0]          off_loc;
   logic [IW-1:0]          line_idx;
   logic [PLANE_WIDTH-1:0] line_bits;

   assign off_loc = ctl.offset[IW-1:0];

   // Up and left take the glyph's lines in order, down and right in reverse
   always_comb begin
      if (ctl.dir == DIR_UP || ctl.dir == DIR_LEFT) begin
         line_idx = off_loc;
      end else begin
         line_idx = IW'(PLANE_WIDTH - 1) - off_loc;
      end
   end

   always_comb begin
      logic [5:0] idx;
      for (int k = 0; k < PLANE_WIDTH; k++) begin
         if (ctl.dir == DIR_UP || ctl.dir == DIR_DN) begin
            idx = 6'(int'(line_idx) * PLANE_WIDTH + k);
         end else begin
            idx = 6'(k * PLANE_WIDTH + int'(line_idx));
         end
         line_bits[k] = ctl.blank ? 1'b0 : src_plane[idx];
      end
   end

   // Whole-plane shift, then the entering row or column is overwritten;
   // anything pushed past the plane area is masked off by the sequencer
   always_comb begin
      unique case (ctl.dir)
         DIR_UP: begin
            next_plane = cur_plane >> PLANE_WIDTH;
            next_plane[(PLANE_WIDTH-1)*PLANE_WIDTH +: PLANE_WIDTH] = line_bits;
         end
         DIR_DN: begin
            next_plane = cur_plane << PLANE_WIDTH;
            next_plane[0 +: PLANE_WIDTH] = line_bits;
         end
         DIR_RT: begin
            next_plane = cur_plane << 1;
            for (int y = 0; y < PLANE_WIDTH; y++) begin
               next_plane[y*PLANE_WIDTH] = line_bits[y];
            end
         end
         default: begin
            next_plane = cur_plane >> 1;
            for (int y = 0; y < PLANE_WIDTH; y++) begin
               next_plane[y*PLANE_WIDTH+PLANE_WIDTH-1] = line_bits[y];
            end
         end
      endcase
   end

endmodule

/* rtl/bps_ctrl.sv */
// Item register, step sequencer, displayed plane and config registers
module bps_ctrl import bps_pkg::*; #(
   parameter int PLANE_WIDTH = PLANE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  item_valid,
   input  logic [PLANE_BITS-1:0] item_glyph,
   input  logic                  item_flush,
   output logic                  item_ready,
   input  logic                  out_free,
   output logic [PLANE_BITS-1:0] cur_plane,
   output logic [PLANE_BITS-1:0] src_plane,
   output step_ctl_type          step_ctl,
   input  logic [PLANE_BITS-1:0] next_plane,
   output logic                  emit,
   output logic [PLANE_BITS-1:0] emit_frame,
   output logic                  emit_last
);

   localparam int AREA = PLANE_WIDTH * PLANE_WIDTH;
   localparam logic [PLANE_BITS-1:0] AREA_MASK =
      (AREA >= PLANE_BITS) ? '1 : ((PLANE_BITS'(1) << AREA) - PLANE_BITS'(1));

   logic [1:0]            dir_ff, dir_in;
   logic [GAP_W-1:0]      gap_ff, gap_in;
   logic                  busy_ff, busy_in;
   logic [PLANE_BITS-1:0] glyph_ff, glyph_in;
   logic                  flush_ff, flush_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  loaded_ff, loaded_in;
   logic [PLANE_BITS-1:0] shown_ff, shown_in;

   logic [GAP_W-1:0]  gap_eff;
   logic [STEP_W-1:0] run_total;
   logic [STEP_W-1:0] step_off;
   logic              last_step;
   logic              drop, load, run, done, accept;

   assign gap_eff   = (gap_ff > GAP_MAX) ? GAP_MAX : gap_ff;
   assign run_total = flush_ff ? STEP_W'(PLANE_WIDTH)
                               : STEP_W'(gap_eff) + STEP_W'(PLANE_WIDTH);
   assign last_step = (step_ff == run_total - STEP_W'(1));
   assign step_off  = step_ff - STEP_W'(gap_eff);

   assign drop = busy_ff && flush_ff && !loaded_ff;
   assign load = busy_ff && !flush_ff && !loaded_ff;
   assign run  = busy_ff && loaded_ff;
   assign emit = (load || run) && out_free;
   assign done = drop || (emit && (load || last_step));

   assign item_ready = !busy_ff || done;
   assign accept     = item_valid && item_ready;

   assign cur_plane       = shown_ff;
   assign src_plane       = glyph_ff;
   assign step_ctl.dir    = dir_ff;
   assign step_ctl.blank  = flush_ff || (step_ff < STEP_W'(gap_eff));
   assign step_ctl.offset = step_off[OFF_W-1:0];

   assign emit_frame = load ? glyph_ff : (next_plane & AREA_MASK);
   assign emit_last  = load || last_step;

   always_comb begin
      dir_in    = dir_ff;
      gap_in    = gap_ff;
      busy_in   = busy_ff;
      glyph_in  = glyph_ff;
      flush_in  = flush_ff;
      step_in   = step_ff;
      loaded_in = loaded_ff;
      shown_in  = shown_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_DIRECTION: dir_in = csr_wdata[1:0];
            default:       gap_in = csr_wdata[GAP_W-1:0];
         endcase
      end

      if (emit) begin
         shown_in = emit_frame;
         step_in  = step_ff + STEP_W'(1);
      end
      if (load) begin
         loaded_in = emit ? 1'b1 : loaded_ff;
      end
      // a flush run leaves the plane blank and returns to idle
      if (emit && run && flush_ff && last_step) begin
         loaded_in = 1'b0;
      end

      if (done) begin
         busy_in = 1'b0;
         step_in = '0;
      end
      if (accept) begin
         busy_in  = 1'b1;
         glyph_in = item_glyph & AREA_MASK;
         flush_in = item_flush;
         step_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= DIR_UP;
         gap_ff    <= GAP_W'(1);
         busy_ff   <= 1'b0;
         step_ff   <= '0;
         loaded_ff <= 1'b0;
         shown_ff  <= '0;
      end else begin
         dir_ff    <= dir_in;
         gap_ff    <= gap_in;
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         loaded_ff <= loaded_in;
         shown_ff  <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      flush_ff <= flush_in;
   end

`include "bitmap_plane_scroller_unit_assert.svh"

   `BPS_ASSERT_NOW(a_step_in_run, busy_ff, step_ff < run_total, "step count past run length")
   `BPS_ASSERT_NEXT(a_flush_blanks, emit && run && flush_ff && last_step, !loaded_ff && shown_ff == '0, "flush did not end blank and idle")
   `BPS_ASSERT_NOW(a_area_only, 1'b1, (shown_ff & ~AREA_MASK) == '0, "bits set beyond the plane")

endmodule

/* rtl/bitmap_plane_scroller_unit.sv */
// Top level of the bitmap plane scroller with its result register
//
//   channel  dir  beat payload                      handshake
//   req      in   glyph_plane[63:0], flush_end      valid/ready
//   rsp      out  frame_plane[63:0], last_of_run    valid/ready
//   csr      in   csr_index, csr_wdata[5:0]         csr_write, no back-pressure
//
// One scroll step per cycle through the shift datapath while rsp is not
// stalled: a glyph run is PLANE_WIDTH + min(gap_lines, 56) steps, a flush
// PLANE_WIDTH steps, the first glyph after idle a single frame and a flush while idle no frame.
// The next item is taken in the cycle the last frame of the current one issues.
// Reset is synchronous; it clears control and the displayed plane and sets config to defaults.
// A stalled rsp holds its beat and the sequencer waits; req stalls meanwhile unless idle.
module bitmap_plane_scroller_unit import bps_pkg::*; #(
   parameter int PLANE_WIDTH = PLANE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bps_req_if.sink               req_chan,
   bps_rsp_if.source             rsp_chan,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PLANE_BITS-1:0] rsp_frame_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic [PLANE_BITS-1:0] cur_plane, src_plane, next_plane, emit_frame;
   step_ctl_type          step_ctl;
   logic                  emit, emit_last;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   bps_ctrl #(.PLANE_WIDTH(PLANE_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (req_chan.valid),
      .item_glyph (req_chan.glyph_plane),
      .item_flush (req_chan.flush_end),
      .item_ready (req_chan.ready),
      .out_free   (out_free),
      .cur_plane  (cur_plane),
      .src_plane  (src_plane),
      .step_ctl   (step_ctl),
      .next_plane (next_plane),
      .emit       (emit),
      .emit_frame (emit_frame),
      .emit_last  (emit_last)
   );

   bps_shift #(.PLANE_WIDTH(PLANE_WIDTH)) u_shift (
      .cur_plane  (cur_plane),
      .src_plane  (src_plane),
      .ctl        (step_ctl),
      .next_plane (next_plane)
   );

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_frame_ff <= emit_frame;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_plane = rsp_frame_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

/* test/tb_top.sv */
// Testbench of the bitmap plane scroller: random and directed glyph streams, checked per frame
`timescale 1ns / 1ps

module tb_top;
   import bps_pkg::*;

   localparam int W = PLANE_WIDTH_DEF;

   typedef struct packed {
      logic [PLANE_BITS-1:0] frame;
      logic                  last;
   } frame_beat_type;

   // Tracks the displayed plane and queues the frames each accepted item must produce
   class scroll_checker;
      logic [1:0]            dir;
      logic [GAP_W-1:0]      gap;
      logic [PLANE_BITS-1:0] shown;
      logic                  loaded;
      frame_beat_type        expected_frames[$];
      int                    mismatches;

      function new();
         dir        = DIR_UP;
         gap        = 6'd1;
         shown      = '0;
         loaded     = 1'b0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DIRECTION)
            dir = data[1:0];
         else if (idx == CSR_GAP_LINES)
            gap = data[GAP_W-1:0];
      endfunction

      function logic [PLANE_BITS-1:0] area_mask();
         if (W * W >= PLANE_BITS)
            return '1;
         return (64'd1 << (W * W)) - 64'd1;
      endfunction

      // shift by one line; the entering line is line off of src (W-1-off for down and right)
      function logic [PLANE_BITS-1:0] scroll_step(logic [PLANE_BITS-1:0] cur,
                                                  logic [PLANE_BITS-1:0] src, int off);
         logic [PLANE_BITS-1:0] nxt;
         logic                  b;
         nxt = '0;
         for (int y = 0; y < W; y++) begin
            for (int x = 0; x < W; x++) begin
               case (dir)
                  DIR_UP:   b = (y < W - 1) ? cur[(y + 1) * W + x] : src[off * W + x];
                  DIR_DN:   b = (y > 0) ? cur[(y - 1) * W + x] : src[(W - 1 - off) * W + x];
                  DIR_RT:   b = (x > 0) ? cur[y * W + x - 1] : src[y * W + W - 1 - off];
                  default:  b = (x < W - 1) ? cur[y * W + x + 1] : src[y * W + off];
               endcase
               nxt[y * W + x] = b;
            end
         end
         return nxt;
      endfunction

      function void queue_run(logic [PLANE_BITS-1:0] src, int blank_lines);
         int total;
         total = blank_lines + W;
         for (int s = 0; s < total; s++) begin
            if (s < blank_lines)
               shown = scroll_step(shown, '0, 0);
            else
               shown = scroll_step(shown, src, s - blank_lines);
            shown &= area_mask();
            expected_frames.push_back('{frame: shown, last: (s + 1 == total)});
         end
      endfunction

      function void note_item(logic [PLANE_BITS-1:0] glyph, logic flush);
         int gap_eff;
         glyph   = glyph & area_mask();
         gap_eff = (gap > GAP_MAX) ? int'(GAP_MAX) : int'(gap);
         if (flush) begin
            if (!loaded)
               return;
            queue_run('0, 0);
            shown  = '0;
            loaded = 1'b0;
         end else if (!loaded) begin
            shown  = glyph;
            loaded = 1'b1;
            expected_frames.push_back('{frame: shown, last: 1'b1});
         end else begin
            queue_run(glyph, gap_eff);
         end
      endfunction

      function void check_frame(logic [PLANE_BITS-1:0] frame, logic last);
         frame_beat_type want;
         if (expected_frames.size() == 0) begin
            $error("unexpected frame beat: frame_plane %h last_of_run %b", frame, last);
            mismatches++;
            return;
         end
         want = expected_frames.pop_front();
         if (frame !== want.frame) begin
            $error("frame_plane mismatch: expected %h, actual %h", want.frame, frame);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last_of_run mismatch: expected %b, actual %b", want.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    idle_pct;
   int                    stall_pct;
   scroll_checker         sc;

   bps_req_if req_bus ();
   bps_rsp_if rsp_bus ();

   bitmap_plane_scroller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sc.check_frame(rsp_bus.frame_plane, rsp_bus.last_of_run);
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      sc.set_register(idx, data);
   endtask

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic push_item(input logic [PLANE_BITS-1:0] glyph, input logic flush);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.glyph_plane <= glyph;
      req_bus.flush_end   <= flush;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sc.note_item(glyph, flush);
      @(negedge clock);
   endtask

   // drain all frames, then allow for a trailing idle flush or a full run
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sc.pending() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [PLANE_BITS-1:0] pick_glyph();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_phase(input int send_idle, input int recv_stall,
                            input int gap_lo, input int gap_hi, input int count);
      logic [1:0] dir;
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      dir = 2'($urandom_range(0, 3));
      // upper data bits are don't-care for the direction register
      write_csr(CSR_DIRECTION, {4'($urandom_range(0, 15)), dir});
      write_csr(CSR_GAP_LINES, 6'($urandom_range(gap_lo, gap_hi)));
      for (int k = 0; k < count; k++)
         push_item(pick_glyph(), $urandom_range(0, 5) == 0);
      settle();
   endtask

   initial begin
      logic [1:0]       dirs[4];
      logic [GAP_W-1:0] gaps[4];
      dirs = '{DIR_UP, DIR_DN, DIR_RT, DIR_LEFT};
      gaps = '{6'd1, 6'd0, 6'd63, 6'd56};
      sc                  = new();
      idle_pct            = 0;
      stall_pct           = 0;
      reset               = 1'b1;
      csr_write           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.glyph_plane = '0;
      req_bus.flush_end   = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: flush while idle, then each direction with extreme gaps
      push_item('1, 1'b1);
      for (int d = 0; d < 4; d++) begin
         if (d != 0) begin
            write_csr(CSR_DIRECTION, {4'b0, dirs[d]});
            write_csr(CSR_GAP_LINES, gaps[d]);
         end
         push_item('1, 1'b0);
         push_item(64'h8000_0000_0000_0001, 1'b0);
         push_item(64'h0123_4567_89ab_cdef, 1'b0);
         push_item('1, 1'b1);
         settle();
      end

      run_phase(0, 0, 0, 3, 25);
      run_phase(56, 0, 0, 3, 25);
      run_phase(0, 56, 0, 3, 25);
      run_phase(36, 36, 0, 3, 25);
      run_phase(0, 0, 4, 12, 25);
      run_phase(56, 0, 57, 63, 25);
      run_phase(0, 56, 0, 2, 25);
      run_phase(36, 36, 0, 6, 25);

      if (sc.pending() != 0)
         $error("%0d expected frame beats never arrived", sc.pending());
      if (sc.mismatches == 0 && sc.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
